>>> rtl/core/ctt_pkg.sv
// shared types, character codes and helper functions of the config text tokenizer
package ctt_pkg;

  // queue between the front and the back part
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // character codes
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // token kinds as seen on the result channel
  typedef enum logic [2:0] {
    KIND_WORD    = 3'd0,
    KIND_QUOTED  = 3'd1,
    KIND_OPEN    = 3'd2,
    KIND_CLOSE   = 3'd3,
    KIND_SEMI    = 3'd4,
    KIND_COMMENT = 3'd5,
    KIND_EOF     = 3'd6,
    KIND_INVALID = 3'd7
  } kind_e;

  // lexer states, one-hot
  typedef enum logic [5:0] {
    ST_START   = 6'b000001,
    ST_WORD    = 6'b000010,
    ST_COMMENT = 6'b000100,
    ST_SQUOTE  = 6'b001000,
    ST_DQUOTE  = 6'b010000,
    ST_ENDQ    = 6'b100000
  } lex_state_e;

  // one classified input byte: its first result and an optional second one
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_append;
    logic       first_done;
    kind_e      first_kind;
    logic       has_second;
    kind_e      second_kind;
  } ctt_entry_t;

  function automatic logic is_space(logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
  endfunction

  function automatic logic is_delim(logic [7:0] c);
    return c inside {CH_LBRACE, CH_RBRACE, CH_SEMI};
  endfunction

  function automatic kind_e delim_kind(logic [7:0] c);
    kind_e k;
    k = KIND_SEMI;
    if (c == CH_LBRACE) k = KIND_OPEN;
    else if (c == CH_RBRACE) k = KIND_CLOSE;
    return k;
  endfunction

endpackage

>>> rtl/core/ctt_if.sv
// valid/ready channel interfaces for text bytes and token results

interface ctt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_input;

  modport source (output valid, text_byte, end_of_input, input ready);
  modport sink   (input valid, text_byte, end_of_input, output ready);
endinterface

interface ctt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       append;
  logic       token_done;
  logic [2:0] kind;
  logic       last;

  modport source (output valid, byte_out, append, token_done, kind, last, input ready);
  modport sink   (input valid, byte_out, append, token_done, kind, last, output ready);
endinterface

>>> rtl/core/ctt_front.sv
// front part: accepts text bytes, runs the lexer state and classifies each byte
module ctt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  ctt_in_if.sink             in_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output ctt_pkg::ctt_entry_t push_data_o
);

  ctt_pkg::lex_state_e state_q, state_d;
  logic                esc_q, esc_d;
  ctt_pkg::ctt_entry_t entry;
  logic                accept;
  logic [7:0]          c;
  logic [7:0]          quote_char;

  assign in_i.ready   = push_ready_i;
  assign accept       = in_i.valid && push_ready_i;
  assign push_valid_o = in_i.valid;
  assign push_data_o  = entry;
  assign c            = in_i.text_byte;
  assign quote_char   = (state_q == ctt_pkg::ST_SQUOTE) ? ctt_pkg::CH_SQUOTE
                                                        : ctt_pkg::CH_DQUOTE;

  // classify the byte against the current lexer state
  always_comb begin
    entry.data_byte    = c;
    entry.first_append = 1'b0;
    entry.first_done   = 1'b0;
    entry.first_kind   = ctt_pkg::KIND_WORD;
    entry.has_second   = 1'b0;
    entry.second_kind  = ctt_pkg::KIND_SEMI;
    state_d            = state_q;
    esc_d              = esc_q;

    if (in_i.end_of_input) begin
      // end of text: one result, open quote is invalid
      entry.data_byte  = ctt_pkg::CH_NUL;
      entry.first_done = 1'b1;
      entry.first_kind = (state_q == ctt_pkg::ST_SQUOTE || state_q == ctt_pkg::ST_DQUOTE)
                         ? ctt_pkg::KIND_INVALID : ctt_pkg::KIND_EOF;
      state_d          = ctt_pkg::ST_START;
      esc_d            = 1'b0;
    end else begin
      case (state_q)
        ctt_pkg::ST_START: begin
          if (ctt_pkg::is_delim(c)) begin
            entry.first_append = 1'b1;
            entry.first_done   = 1'b1;
            entry.first_kind   = ctt_pkg::delim_kind(c);
          end else if (c == ctt_pkg::CH_HASH) begin
            entry.first_append = 1'b1;
            state_d            = ctt_pkg::ST_COMMENT;
          end else if (c == ctt_pkg::CH_SQUOTE) begin
            entry.first_append = 1'b1;
            state_d            = ctt_pkg::ST_SQUOTE;
          end else if (c == ctt_pkg::CH_DQUOTE) begin
            entry.first_append = 1'b1;
            state_d            = ctt_pkg::ST_DQUOTE;
          end else if (ctt_pkg::is_space(c)) begin
            entry.first_append = 1'b0;
          end else if (c == ctt_pkg::CH_BSLASH) begin
            esc_d   = 1'b1;
            state_d = ctt_pkg::ST_WORD;
          end else begin
            entry.first_append = 1'b1;
            state_d            = ctt_pkg::ST_WORD;
          end
        end
        ctt_pkg::ST_COMMENT: begin
          if (c == ctt_pkg::CH_CR || c == ctt_pkg::CH_LF) begin
            entry.first_done = 1'b1;
            entry.first_kind = ctt_pkg::KIND_COMMENT;
            state_d          = ctt_pkg::ST_START;
            esc_d            = 1'b0;
          end else begin
            entry.first_append = 1'b1;
          end
        end
        ctt_pkg::ST_SQUOTE, ctt_pkg::ST_DQUOTE: begin
          if (c == ctt_pkg::CH_BSLASH) begin
            entry.first_append = esc_q;
            esc_d              = ~esc_q;
          end else begin
            entry.first_append = 1'b1;
            if (c == quote_char && !esc_q) state_d = ctt_pkg::ST_ENDQ;
            esc_d = 1'b0;
          end
        end
        ctt_pkg::ST_ENDQ: begin
          // only whitespace or a semicolon may follow a closing quote
          entry.first_done = 1'b1;
          if (ctt_pkg::is_space(c)) begin
            entry.first_kind = ctt_pkg::KIND_QUOTED;
          end else if (c == ctt_pkg::CH_SEMI) begin
            entry.first_kind  = ctt_pkg::KIND_QUOTED;
            entry.has_second  = 1'b1;
            entry.second_kind = ctt_pkg::KIND_SEMI;
          end else begin
            entry.first_kind = ctt_pkg::KIND_INVALID;
          end
          state_d = ctt_pkg::ST_START;
          esc_d   = 1'b0;
        end
        default: begin
          // plain word
          if (c == ctt_pkg::CH_BSLASH) begin
            entry.first_append = esc_q;
            esc_d              = ~esc_q;
          end else if (!esc_q && ctt_pkg::is_space(c)) begin
            entry.first_done = 1'b1;
            entry.first_kind = ctt_pkg::KIND_WORD;
            state_d          = ctt_pkg::ST_START;
            esc_d            = 1'b0;
          end else if (!esc_q && ctt_pkg::is_delim(c)) begin
            entry.first_done  = 1'b1;
            entry.first_kind  = ctt_pkg::KIND_WORD;
            entry.has_second  = 1'b1;
            entry.second_kind = ctt_pkg::delim_kind(c);
            state_d           = ctt_pkg::ST_START;
            esc_d             = 1'b0;
          end else begin
            entry.first_append = 1'b1;
            esc_d              = 1'b0;
          end
        end
      endcase
    end
  end

  // lexer state advances on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ctt_pkg::ST_START;
      esc_q   <= 1'b0;
    end else if (accept) begin
      state_q <= state_d;
      esc_q   <= esc_d;
    end
  end

endmodule

>>> rtl/core/ctt_queue.sv
// short queue of classified bytes between the front and the back part
module ctt_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  ctt_pkg::ctt_entry_t push_data_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output ctt_pkg::ctt_entry_t pop_data_o
);

  ctt_pkg::ctt_entry_t                  mem_q [ctt_pkg::QUEUE_DEPTH];
  logic [ctt_pkg::QUEUE_PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [ctt_pkg::QUEUE_CNT_W-1:0]      count_q;
  logic                                 push, pop;

  assign push_ready_o = count_q != ctt_pkg::QUEUE_CNT_W'(ctt_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == ctt_pkg::QUEUE_PTR_W'(ctt_pkg::QUEUE_DEPTH - 1))
                    ? '0 : wr_ptr_q + ctt_pkg::QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == ctt_pkg::QUEUE_PTR_W'(ctt_pkg::QUEUE_DEPTH - 1))
                    ? '0 : rd_ptr_q + ctt_pkg::QUEUE_PTR_W'(1);
      end
      if (push && !pop) count_q <= count_q + ctt_pkg::QUEUE_CNT_W'(1);
      else if (pop && !push) count_q <= count_q - ctt_pkg::QUEUE_CNT_W'(1);
    end
  end

endmodule

>>> rtl/core/ctt_back.sv
// back part: expands each classified byte into one or two results
module ctt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  ctt_pkg::ctt_entry_t pop_data_i,
  ctt_out_if.source           out_o
);

  logic                out_valid_q;
  logic [7:0]          byte_q;
  logic                append_q, done_q, last_q;
  ctt_pkg::kind_e      kind_q;
  logic                second_q;
  logic                load;

  // output register is free when empty or being taken
  assign load        = !out_valid_q || out_o.ready;
  assign pop_ready_o = load && (second_q || !pop_data_i.has_second);

  assign out_o.valid      = out_valid_q;
  assign out_o.byte_out   = byte_q;
  assign out_o.append     = append_q;
  assign out_o.token_done = done_q;
  assign out_o.kind       = kind_q;
  assign out_o.last       = last_q;

  // result payload
  always_ff @(posedge clk_i) begin
    if (load && pop_valid_i) begin
      byte_q <= pop_data_i.data_byte;
      if (second_q) begin
        append_q <= 1'b1;
        done_q   <= 1'b1;
        kind_q   <= pop_data_i.second_kind;
        last_q   <= 1'b1;
      end else begin
        append_q <= pop_data_i.first_append;
        done_q   <= pop_data_i.first_done;
        kind_q   <= pop_data_i.first_kind;
        last_q   <= !pop_data_i.has_second;
      end
    end
  end

  // output valid and second-result phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else if (load) begin
      out_valid_q <= pop_valid_i;
      if (pop_valid_i) second_q <= !second_q && pop_data_i.has_second;
    end
  end

endmodule

>>> rtl/core/config_text_tokenizer_top.sv
// Configuration text tokenizer. Takes one text byte (or an end-of-input marker)
// per cycle while the queue has room, and gives one result per byte, or two when
// a brace or semicolon ends a word or a semicolon ends a quoted word. The front
// lexer accepts a byte every cycle while the two-entry queue has room; the back
// part drives one result per cycle from its output register while the output is
// taken, and a two-result byte holds its queue entry until the second is loaded.
// Each byte passes through a queue entry and then the output register before its
// first result appears. There are no configuration registers.
module config_text_tokenizer_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  ctt_in_if.sink    in_i,
  ctt_out_if.source out_o
);

  logic                push_valid, push_ready;
  logic                pop_valid, pop_ready;
  ctt_pkg::ctt_entry_t push_data, pop_data;

  // lexer and classifier
  ctt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // decoupling queue
  ctt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // result sequencer
  ctt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

endmodule

>>> rtl/core/ctt_checker.sv
// port-level checks of the config text tokenizer and their binding
module ctt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] byte_out_i,
  input logic       append_i,
  input logic       token_done_i,
  input logic [2:0] kind_i,
  input logic       last_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(byte_out_i) && $stable(last_i))
    else $error("stalled result changed");

  // a first of two results only ends a word or a quoted word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_i |-> token_done_i && !append_i &&
      (kind_i == ctt_pkg::KIND_WORD || kind_i == ctt_pkg::KIND_QUOTED))
    else $error("bad first result of a pair");

  // the second result follows at once, on the same byte, as an appended delimiter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=> out_valid_i && last_i && append_i &&
      token_done_i && byte_out_i == $past(byte_out_i))
    else $error("second result of a pair missing or wrong");

  // end-of-file results carry no character and close the transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && token_done_i && kind_i == ctt_pkg::KIND_EOF |-> last_i && !append_i &&
      byte_out_i == ctt_pkg::CH_NUL)
    else $error("bad eof result");

endmodule

bind config_text_tokenizer_top ctt_checker u_ctt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .byte_out_i   (out_o.byte_out),
  .append_i     (out_o.append),
  .token_done_i (out_o.token_done),
  .kind_i       (out_o.kind),
  .last_i       (out_o.last)
);

>>> tb/ctt_checker.sv
// result checker for the config text tokenizer: predicts every result and compares
module ctt_result_checker (
  input  logic clk_i,
  input  logic rst_ni,
  ctt_in_if    in_mon,
  ctt_out_if   out_mon,
  input  logic drain_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ctt_pkg::*;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       append;
    logic       token_done;
    kind_e      kind;
    logic       last;
  } token_result_t;

  token_result_t token_q[$];
  token_result_t got;
  token_result_t want;
  lex_state_e    lex_st = ST_START;
  logic          esc_pend = 1'b0;
  int            mismatches;
  int            checked;
  bit            drained;

  // one printed line and one count per mismatch
  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic string show(input token_result_t r);
    return $sformatf("byte %02h app %0b done %0b kind %s last %0b",
                     r.data_byte, r.append, r.token_done, r.kind.name(), r.last);
  endfunction

  // kind reads as word whenever no token ends
  function automatic void push_result(input logic [7:0] b, input logic app, input logic done,
                                      input kind_e k, input logic fin);
    token_result_t r;
    r.data_byte  = b;
    r.append     = app;
    r.token_done = done;
    r.kind       = done ? k : KIND_WORD;
    r.last       = fin;
    token_q = {token_q, r};
  endfunction

  // lexer step: queues the one or two results a transaction causes
  function automatic void predict_tokens(input logic [7:0] c, input logic eoi);
    logic       blank;
    logic       delim;
    kind_e      dk;
    logic [7:0] closer;
    blank  = c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    delim  = c == CH_LBRACE || c == CH_RBRACE || c == CH_SEMI;
    dk     = (c == CH_LBRACE) ? KIND_OPEN : ((c == CH_RBRACE) ? KIND_CLOSE : KIND_SEMI);
    closer = (lex_st == ST_SQUOTE) ? CH_SQUOTE : CH_DQUOTE;
    if (eoi) begin
      // an open quote at end of text is invalid, anything else gives an end-of-file result
      push_result(CH_NUL, 1'b0, 1'b1,
                  (lex_st == ST_SQUOTE || lex_st == ST_DQUOTE) ? KIND_INVALID : KIND_EOF, 1'b1);
      lex_st   = ST_START;
      esc_pend = 1'b0;
    end else begin
      case (lex_st)
        ST_START: begin
          if (delim) begin
            push_result(c, 1'b1, 1'b1, dk, 1'b1);
          end else if (blank) begin
            push_result(c, 1'b0, 1'b0, KIND_WORD, 1'b1);
          end else begin
            // a leading backslash opens a word and escapes the next byte
            push_result(c, c != CH_BSLASH, 1'b0, KIND_WORD, 1'b1);
            if (c == CH_HASH) lex_st = ST_COMMENT;
            else if (c == CH_SQUOTE) lex_st = ST_SQUOTE;
            else if (c == CH_DQUOTE) lex_st = ST_DQUOTE;
            else begin
              lex_st   = ST_WORD;
              esc_pend = (c == CH_BSLASH);
            end
          end
        end
        ST_COMMENT: begin
          if (c == CH_CR || c == CH_LF) begin
            push_result(c, 1'b0, 1'b1, KIND_COMMENT, 1'b1);
            lex_st   = ST_START;
            esc_pend = 1'b0;
          end else begin
            push_result(c, 1'b1, 1'b0, KIND_WORD, 1'b1);
          end
        end
        ST_SQUOTE, ST_DQUOTE: begin
          if (c == CH_BSLASH) begin
            push_result(c, esc_pend, 1'b0, KIND_WORD, 1'b1);
            esc_pend = !esc_pend;
          end else begin
            push_result(c, 1'b1, 1'b0, KIND_WORD, 1'b1);
            if (c == closer && !esc_pend) lex_st = ST_ENDQ;
            esc_pend = 1'b0;
          end
        end
        ST_ENDQ: begin
          if (blank) begin
            push_result(c, 1'b0, 1'b1, KIND_QUOTED, 1'b1);
          end else if (c == CH_SEMI) begin
            push_result(c, 1'b0, 1'b1, KIND_QUOTED, 1'b0);
            push_result(c, 1'b1, 1'b1, KIND_SEMI, 1'b1);
          end else begin
            push_result(c, 1'b0, 1'b1, KIND_INVALID, 1'b1);
          end
          lex_st   = ST_START;
          esc_pend = 1'b0;
        end
        default: begin
          // plain word
          if (c == CH_BSLASH) begin
            push_result(c, esc_pend, 1'b0, KIND_WORD, 1'b1);
            esc_pend = !esc_pend;
          end else if (!esc_pend && blank) begin
            push_result(c, 1'b0, 1'b1, KIND_WORD, 1'b1);
            lex_st = ST_START;
          end else if (!esc_pend && delim) begin
            push_result(c, 1'b0, 1'b1, KIND_WORD, 1'b0);
            push_result(c, 1'b1, 1'b1, dk, 1'b1);
            lex_st = ST_START;
          end else begin
            push_result(c, 1'b1, 1'b0, KIND_WORD, 1'b1);
            esc_pend = 1'b0;
          end
        end
      endcase
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q.delete();
      lex_st       = ST_START;
      esc_pend     = 1'b0;
      mismatches   = 0;
      checked      = 0;
      drained      = 1'b0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      // input transaction: queue its predicted results
      if (in_mon.valid && in_mon.ready) begin
        predict_tokens(in_mon.text_byte, in_mon.end_of_input);
      end
      // output transaction: compare with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.byte_out, out_mon.append, out_mon.token_done,
                kind_e'(out_mon.kind), out_mon.last};
        if (token_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result: %s", show(got)));
        end else begin
          want = token_q.pop_front();
          checked++;
          if (got !== want) begin
            flag_mismatch($sformatf("result %0d: got %s, expected %s",
                                    checked, show(got), show(want)));
          end
        end
      end
      // leftovers once the run has drained
      if (drain_i && !drained) begin
        drained = 1'b1;
        if (token_q.size() != 0) begin
          flag_mismatch($sformatf("%0d expected results never arrived", token_q.size()));
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= token_q.size();
      checked_o    <= checked;
    end
  end

endmodule

>>> tb/testbench.sv
// top of the tokenizer testbench: clock, reset, text stimulus, output stalls and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ctt_pkg::*;

  localparam int OUT_HOLD_CYCLES = 60;
  localparam logic [8:0] EOI_MARK = 9'h100;

  logic clk_i;
  logic rst_ni;
  logic drain;
  int   fail_count;
  int   pending;
  int   checked;
  int   bytes_sent;
  int   eoi_sent;
  int   rx_hold_len;
  bit   tx_gaps_en;
  bit   rx_stall_en;

  // directed opening: blanks, delimiters, byte extremes, escapes, quotes, comment, end cases
  logic [8:0] directed_seq [25] = '{
    9'(CH_SPACE), 9'(CH_TAB), 9'(CH_CR), 9'(CH_LF),
    9'(CH_LBRACE), 9'(CH_RBRACE), 9'(CH_SEMI),
    9'(CH_NUL), 9'h0FF, 9'(CH_LBRACE),
    9'(CH_BSLASH), 9'(CH_SEMI), 9'(CH_RBRACE),
    9'(CH_DQUOTE), 9'("x"), 9'(CH_DQUOTE), 9'(CH_SEMI),
    9'(CH_HASH), 9'(CH_LF),
    9'(CH_SQUOTE), 9'(CH_SQUOTE), 9'("z"),
    9'(CH_SQUOTE), EOI_MARK, EOI_MARK
  };

  ctt_in_if  in_if ();
  ctt_out_if out_if ();

  config_text_tokenizer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  ctt_result_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .drain_i      (drain),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d results still expected", pending);
    $display("TEST FAILED");
    $finish;
  end

  // output side: random stall bursts plus one long requested hold-off
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_len != 0) begin
        out_if.ready <= 1'b0;
        repeat (rx_hold_len) @(negedge clk_i);
        rx_hold_len = 0;
      end else if (rx_stall_en && $urandom_range(0, 6) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // one input transaction, optionally after an idle burst with junk payload
  task automatic send_item(input logic [7:0] b, input logic eoi);
    int gap;
    if (tx_gaps_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk_i);
      in_if.valid        <= 1'b0;
      in_if.text_byte    <= 8'($urandom);
      in_if.end_of_input <= 1'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid        <= 1'b1;
    in_if.text_byte    <= eoi ? 8'($urandom) : b;
    in_if.end_of_input <= eoi;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (eoi) eoi_sent++;
    else bytes_sent++;
  endtask

  // printable byte with no meaning to the lexer
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126));
    while (c inside {CH_LBRACE, CH_RBRACE, CH_SEMI, CH_HASH, CH_BSLASH, CH_DQUOTE, CH_SQUOTE});
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] delim_char();
    case ($urandom_range(0, 2))
      0: return CH_LBRACE;
      1: return CH_RBRACE;
      default: return CH_SEMI;
    endcase
  endfunction

  // one piece of config text: mostly well-formed tokens, some noise and cut-off text
  task automatic send_fragment();
    int         pick;
    int         n;
    logic [7:0] q;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      // word with occasional escapes, ended by a blank or a delimiter
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(CH_BSLASH, 0);
          send_item(8'($urandom), 0);
        end else begin
          send_item(plain_char(), 0);
        end
      end
      send_item($urandom_range(0, 1) ? blank_char() : delim_char(), 0);
    end else if (pick < 45) begin
      // quoted word, then a blank, a semicolon or a stray byte
      q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
      send_item(q, 0);
      repeat ($urandom_range(0, 6)) begin
        case ($urandom_range(0, 7))
          0: begin
            send_item(CH_BSLASH, 0);
            send_item(8'($urandom), 0);
          end
          1: send_item((q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE, 0);
          2: send_item(blank_char(), 0);
          default: send_item(plain_char(), 0);
        endcase
      end
      send_item(q, 0);
      n = $urandom_range(0, 9);
      send_item((n < 4) ? blank_char() : ((n < 8) ? CH_SEMI : 8'($urandom)), 0);
    end else if (pick < 57) begin
      send_item(delim_char(), 0);
    end else if (pick < 67) begin
      // comment body may hold any byte but a line end
      send_item(CH_HASH, 0);
      repeat ($urandom_range(0, 8)) begin
        do q = 8'($urandom);
        while (q == CH_CR || q == CH_LF);
        send_item(q, 0);
      end
      send_item($urandom_range(0, 1) ? CH_CR : CH_LF, 0);
    end else if (pick < 77) begin
      repeat ($urandom_range(1, 3)) send_item(blank_char(), 0);
    end else if (pick < 88) begin
      repeat ($urandom_range(1, 4)) send_item(8'($urandom), 0);
    end else if (pick < 94) begin
      send_item(CH_NUL, 1'b1);
    end else begin
      // text cut short: open quote, dangling backslash or bare word
      case ($urandom_range(0, 2))
        0: begin
          send_item($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE, 0);
          repeat ($urandom_range(0, 3)) send_item(plain_char(), 0);
        end
        1: send_item(CH_BSLASH, 0);
        default: send_item(plain_char(), 0);
      endcase
      send_item(CH_NUL, 1'b1);
    end
  endtask

  // random text up to a transaction count, idling switched in stretches when allowed
  task automatic run_random(input int upto, input bit idle);
    while (bytes_sent + eoi_sent < upto) begin
      if (idle && $urandom_range(0, 19) == 0) tx_gaps_en = !tx_gaps_en;
      if (idle && $urandom_range(0, 19) == 0) rx_stall_en = !rx_stall_en;
      send_fragment();
    end
  endtask

  // stimulus and verdict
  initial begin
    int waited;
    in_if.valid        = 1'b0;
    in_if.text_byte    = '0;
    in_if.end_of_input = 1'b0;
    drain       = 1'b0;
    rst_ni      = 1'b0;
    tx_gaps_en  = 1'b1;
    rx_stall_en = 1'b1;
    rx_hold_len = 0;
    bytes_sent  = 0;
    eoi_sent    = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_seq[i]) send_item(directed_seq[i][7:0], directed_seq[i][8]);
    run_random(450, 1'b1);

    // long output hold-off while text keeps coming, so the input backs up
    tx_gaps_en  = 1'b0;
    rx_stall_en = 1'b0;
    rx_hold_len = OUT_HOLD_CYCLES;
    repeat (12) send_fragment();

    // sender pause until everything has come out
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);

    tx_gaps_en  = 1'b1;
    rx_stall_en = 1'b1;
    run_random(780, 1'b1);

    // last stretch at full rate
    tx_gaps_en  = 1'b0;
    rx_stall_en = 1'b0;
    run_random(920, 1'b0);

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 5000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (4) @(negedge clk_i);
    drain <= 1'b1;
    repeat (3) @(negedge clk_i);

    $display("covered %0d text bytes and %0d end-of-input markers, %0d results checked",
             bytes_sent, eoi_sent, checked);
    $display("with idle bursts on both sides, a %0d-cycle output hold-off and a drain pause",
             OUT_HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
